// ----- hdl/pushback_char_stack_macros.svh -----
// Assertion macros for the pushback character stack.
`ifndef PUSHBACK_CHAR_STACK_MACROS_SVH
`define PUSHBACK_CHAR_STACK_MACROS_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define PCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define PCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PCS_ASSERT(label, prop, msg)
`define PCS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- hdl/pcs_pkg.sv -----
`timescale 1ns / 1ps

package pcs_pkg;

  // Default number of stack entries
  localparam int StackDepthDef = 65536;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_READ = 3'd1,
    OP_SAVE = 3'd2,
    OP_SETB = 3'd3,
    OP_DEC  = 3'd4,
    OP_HEX  = 3'd5
  } pcs_op_e;

  // Character codes
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;

  // Reciprocal of ten, scaled by 2^35
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  localparam logic [31:0] Pow10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  // Control from the sequencer to the digit unit
  typedef struct packed {
    logic load;
    logic hex;
    logic step;
  } pcs_dig_ctl_t;

  // Status from the digit unit
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       has_tail;
    logic [7:0] tail_ch;
    logic [3:0] count;
  } pcs_dig_st_t;

  // Number of decimal digits of an unsigned value
  function automatic logic [3:0] dec_digits(input logic [31:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 10; k++) begin
      if (v >= Pow10[k]) n = n + 4'd1;
    end
    return n;
  endfunction

  // Number of hex digits of a value, at least one
  function automatic logic [3:0] hex_digits(input logic [31:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if (v[4*k +: 4] != 4'd0) n = 4'(k + 1);
    end
    return n;
  endfunction

endpackage

// ----- hdl/pushback_char_stack.sv -----
// Push byte, base save/set and stream pass-through: result strobe in the cycle after accept.
// Stack read: one registered memory read, then the result strobe. Decimal push writes the
// digits and a sign; hex push writes the digits and a '#'; one character per cycle,
// bounded by the single memory write port. One transaction at a time, busy until done.
// Reset empties the stack (top and base at the depth); memory contents are not cleared.
// done_o is a one-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "pushback_char_stack_macros.svh"

module pushback_char_stack import pcs_pkg::*; #(
  parameter int StackDepth = StackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op_i,
  input  logic [7:0]         char_in_i,
  input  logic signed [8:0]  stream_char_i,
  input  logic [16:0]        new_base_i,
  input  logic signed [31:0] number_i,
  output logic               done_o,
  output logic signed [8:0]  char_out_o,
  output logic               from_stream_o,
  output logic [16:0]        old_base_o,
  output logic               overflow_o
);

  localparam int AddrW = $clog2(StackDepth);
  localparam int PosW  = AddrW + 1;
  localparam int CmpW  = (PosW > 17) ? PosW : 17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIGIT,
    S_TAIL
  } state_e;

  state_e            state_q, state_d;
  logic [PosW-1:0]   top_q, top_d;
  logic [PosW-1:0]   base_q, base_d;
  logic              done_q, done_d;
  logic signed [8:0] char_out_q, char_out_d;
  logic              from_stream_q, from_stream_d;
  logic [16:0]       old_base_q, old_base_d;
  logic              overflow_q, overflow_d;

  logic [PosW-1:0]   top_m1;
  logic [PosW-1:0]   nb_sat;
  pcs_op_e           op;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  pcs_dig_ctl_t      dig_ctl;
  pcs_dig_st_t       dig_st;

  assign op     = pcs_op_e'(op_i);
  assign top_m1 = top_q - 1'b1;
  assign nb_sat = (CmpW'(new_base_i) > CmpW'(StackDepth)) ? PosW'(StackDepth)
                                                          : PosW'(new_base_i);

  // Stack memory
  pcs_mem #(
    .StackDepth(StackDepth),
    .AddrW     (AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Digit generator for decimal and hex pushes
  pcs_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .number_i(number_i),
    .ctl_i   (dig_ctl),
    .st_o    (dig_st)
  );

  // Sequencer next state
  always_comb begin
    state_d       = state_q;
    top_d         = top_q;
    base_d        = base_q;
    done_d        = 1'b0;
    char_out_d    = '0;
    from_stream_d = 1'b0;
    old_base_d    = '0;
    overflow_d    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = top_m1[AddrW-1:0];
    mem_wdata     = char_in_i;
    mem_re        = 1'b0;
    mem_raddr     = top_q[AddrW-1:0];
    dig_ctl       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_PUSH: begin
              done_d = 1'b1;
              if (top_q == '0) begin
                overflow_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                top_d  = top_m1;
              end
            end
            OP_READ: begin
              if (top_q >= base_q) begin
                done_d        = 1'b1;
                char_out_d    = stream_char_i;
                from_stream_d = 1'b1;
              end else begin
                mem_re  = 1'b1;
                state_d = S_READ;
              end
            end
            OP_SAVE: begin
              done_d     = 1'b1;
              old_base_d = 17'(base_q);
              base_d     = top_q;
            end
            OP_SETB: begin
              done_d = 1'b1;
              base_d = nb_sat;
            end
            OP_DEC: begin
              dig_ctl.load = 1'b1;
              state_d      = S_CHECK;
            end
            OP_HEX: begin
              dig_ctl.load = 1'b1;
              dig_ctl.hex  = 1'b1;
              state_d      = S_CHECK;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        char_out_d = $signed({1'b0, mem_rdata});
        top_d      = top_q + 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_CHECK: begin
        // Refuse the whole push when the text does not fit
        if (top_q < PosW'(dig_st.count)) begin
          overflow_d = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        mem_we       = 1'b1;
        mem_wdata    = dig_st.ch;
        top_d        = top_m1;
        dig_ctl.step = 1'b1;
        if (dig_st.last) begin
          if (dig_st.has_tail) begin
            state_d = S_TAIL;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_wdata = dig_st.tail_ch;
        top_d     = top_m1;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, stack pointers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      top_q         <= PosW'(StackDepth);
      base_q        <= PosW'(StackDepth);
      done_q        <= 1'b0;
      char_out_q    <= '0;
      from_stream_q <= 1'b0;
      old_base_q    <= '0;
      overflow_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      top_q         <= top_d;
      base_q        <= base_d;
      done_q        <= done_d;
      char_out_q    <= char_out_d;
      from_stream_q <= from_stream_d;
      old_base_q    <= old_base_d;
      overflow_q    <= overflow_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign char_out_o    = char_out_q;
  assign from_stream_o = from_stream_q;
  assign old_base_o    = old_base_q;
  assign overflow_o    = overflow_q;

  // Checks
  `PCS_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while a transaction is open")
  `PCS_ASSERT(a_top_range, top_q <= PosW'(StackDepth), "stack top beyond depth")
  `PCS_ASSERT(a_base_range, base_q <= PosW'(StackDepth), "stack base beyond depth")
  `PCS_ASSERT(a_short_op, (start && !busy) |=> (done_o || busy), "accepted op went nowhere")
  `PCS_ASSERT(a_ovf_push, overflow_o |-> $past(state_q == S_CHECK || op_i == OP_PUSH), "bad overflow")

endmodule

// ----- hdl/pcs_mem.sv -----
`timescale 1ns / 1ps

module pcs_mem import pcs_pkg::*; #(
  parameter int StackDepth = StackDepthDef,
  parameter int AddrW      = $clog2(StackDepth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [StackDepth];
  logic [7:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pcs_digits.sv -----
`timescale 1ns / 1ps

module pcs_digits import pcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  number_i,
  input  pcs_dig_ctl_t        ctl_i,
  output pcs_dig_st_t         st_o
);

  logic [31:0] val_q, val_d;
  logic        hex_q, neg_q;
  logic        neg_d;
  logic [31:0] num_u;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] quot10;
  logic [3:0]  digit;
  logic [31:0] val_shr;

  assign num_u = $unsigned(number_i);
  assign neg_d = !ctl_i.hex && num_u[31];

  // Divide by ten through the scaled reciprocal
  assign prod    = {32'b0, val_q} * {32'b0, Recip10};
  assign quot    = {3'b0, prod[63:35]};
  assign quot10  = {quot[30:0], 1'b0} + {quot[28:0], 3'b0};
  assign val_shr = {4'b0, val_q[31:4]};
  assign digit   = hex_q ? val_q[3:0] : (val_q[3:0] - quot10[3:0]);

  // Value register: loaded with the magnitude, then one digit per step
  always_comb begin
    val_d = val_q;
    if (ctl_i.load) begin
      val_d = neg_d ? (32'd0 - num_u) : num_u;
    end else if (ctl_i.step) begin
      val_d = hex_q ? val_shr : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_q <= 1'b0;
      neg_q <= 1'b0;
    end else if (ctl_i.load) begin
      hex_q <= ctl_i.hex;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Status toward the sequencer
  always_comb begin
    st_o.ch       = (digit < 4'd10) ? (CharZero + {4'b0, digit})
                                    : (CharUpperA + {4'b0, digit} - 8'd10);
    st_o.last     = hex_q ? (val_shr == 32'd0) : (quot == 32'd0);
    st_o.has_tail = hex_q || neg_q;
    st_o.tail_ch  = hex_q ? CharHash : CharMinus;
    st_o.count    = hex_q ? (hex_digits(val_q) + 4'd1)
                          : (dec_digits(val_q) + {3'b0, neg_q});
  end

endmodule
